// ===== hw/rtl/wrs_pkg.sv =====
// shared widths, codes and types for the windowed running statistics block
`default_nettype none

package wrs_pkg;

    localparam int TIME_W     = 63;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 17;
    localparam int SUM_W      = 48;
    localparam int FRAC_BITS  = 16;
    localparam int MEAN_GUARD = 16;
    localparam int MEAN_W     = VAL_W + MEAN_GUARD;
    localparam int DELTA_W    = MEAN_W + 1;
    localparam int MAG_W      = MEAN_W;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int M2_W       = 64;
    localparam int SPREAD_W   = 47;
    localparam int DIV_W      = M2_W;
    localparam int DIVSR_W    = CNT_W;
    localparam int DIV_STEP_W = $clog2(DIV_W + 1);
    localparam int MUL_STEP_W = $clog2(MAG_W + 1);
    localparam int MAX_COUNT  = 65536;
    localparam int IN_W       = ((TIME_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_USED   = 1 + CNT_W + 3 * VAL_W + SUM_W + SPREAD_W + 1;
    localparam int OUT_W      = ((OUT_USED + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_COUNT);

    typedef enum logic [0:0] {
        REG_WINDOW_BEGIN = 1'b0,
        REG_WINDOW_END   = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAKE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_MEAN_UPD,
        ST_DELTA2,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_M2_UPD,
        ST_FINISH,
        ST_VAR_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } div_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wrs_serial_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module wrs_serial_div import wrs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire div_ctl_t           ctl,
    input  wire logic [DIV_W-1:0]   dividend,
    input  wire logic [DIVSR_W-1:0] divisor,
    output logic                    done,
    output logic [DIV_W-1:0]        quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] left_reg;
    logic [DIV_W-1:0]      dvd_reg;
    logic [DIVSR_W-1:0]    rem_reg;
    logic [DIVSR_W-1:0]    dsr_reg;

    logic [DIVSR_W:0]      shifted;
    logic                  ge;
    logic [DIVSR_W:0]      diff;
    logic [DIVSR_W-1:0]    rem_next;
    logic [DIV_W-1:0]      dvd_next;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DIV_W-1]};
        ge       = shifted >= {1'b0, dsr_reg};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = ge ? diff[DIVSR_W-1:0] : shifted[DIVSR_W-1:0];
        // quotient bits enter from the bottom as the dividend leaves the top
        dvd_next = {dvd_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                left_reg <= ctl.steps;
            end
            else if (busy_reg)
            begin
                left_reg <= left_reg - 1'b1;
                if (left_reg == DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wrs_serial_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module wrs_serial_mul import wrs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MAG_W-1:0] mcand,
    input  wire logic [MAG_W-1:0] mplier,
    output logic                  done,
    output logic [PROD_W-1:0]     product
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [MUL_STEP_W-1:0] left_reg;
    logic [MAG_W-1:0]      mcand_reg;
    logic [PROD_W-1:0]     prod_reg;

    logic [MAG_W:0]        part_sum;
    logic [PROD_W-1:0]     prod_next;

    always_comb
    begin
        // multiplier bits sit in the low half and are consumed lsb first
        part_sum  = {1'b0, prod_reg[PROD_W-1:MAG_W]}
                  + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next = {part_sum, prod_reg[MAG_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                left_reg <= MUL_STEP_W'(MAG_W);
            end
            else if (busy_reg)
            begin
                left_reg <= left_reg - 1'b1;
                if (left_reg == MUL_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            prod_reg  <= {{MAG_W{1'b0}}, mplier};
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/windowed_running_statistics.sv =====
// a sample outside the window is taken straight from idle; a kept sample passes through the
// bit-serial mean divider (48 steps) and the bit-serial deviation multiplier (48 steps)
// before a new sample is accepted; a last sample adds the variance division when two or more
// samples were kept in a valid window; the result then waits in the output register until taken,
// and a further result holds the input until that register is free
// rst_n clears the window registers, all accumulators and the output valid at once
`default_nettype none

module windowed_running_statistics import wrs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [TIME_W-1:0] cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,  // sample_time, sample_value, pad
    input  wire logic              s_axis_tlast,  // last_sample
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // found, sample_count, minimum, maximum, total, average, spread, count_overflow, pad
    output logic [OUT_W-1:0]       m_axis_tdata
);

    localparam logic signed [SUM_W:0] SUM_HI = {2'b00, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W:0] SUM_LO = {2'b11, {(SUM_W-1){1'b0}}};
    localparam logic signed [MEAN_W:0] ROUND_HALF =
        {{(MEAN_W+1-MEAN_GUARD){1'b0}}, 1'b1, {(MEAN_GUARD-1){1'b0}}};
    localparam logic signed [MEAN_W:0] AVG_HI =
        {{(MEAN_W+2-VAL_W){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [MEAN_W:0] AVG_LO =
        {{(MEAN_W+2-VAL_W){1'b1}}, {(VAL_W-1){1'b0}}};

    state_t state_reg, state_next;

    logic [TIME_W-1:0]        win_begin_reg;
    logic [TIME_W-1:0]        win_end_reg;

    logic [CNT_W-1:0]         cnt_reg;
    logic                     sat_reg;
    logic signed [VAL_W-1:0]  low_reg;
    logic signed [VAL_W-1:0]  high_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [MEAN_W-1:0] mean_reg;
    logic [M2_W-1:0]          m2_reg;

    logic signed [VAL_W-1:0]   value_reg;
    logic                      last_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic signed [DELTA_W-1:0] delta2_reg;
    logic                      found_reg;
    logic                      var_en_reg;

    logic                      out_valid_reg;
    logic [OUT_W-1:0]          out_data_reg;

    logic [TIME_W-1:0]         in_time;
    logic signed [VAL_W-1:0]   in_value;
    logic                      in_take;
    logic                      keep_in;
    logic signed [MEAN_W-1:0]  x_val;
    logic signed [DELTA_W-1:0] delta_calc;
    logic [DELTA_W-1:0]        delta_neg;
    logic [DELTA_W-1:0]        delta2_neg;
    logic [MAG_W-1:0]          delta_mag;
    logic [MAG_W-1:0]          delta2_mag;

    logic [CNT_W-1:0]          cnt_upd;
    logic                      sat_upd;
    logic                      first_kept;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_upd;
    logic [DELTA_W-1:0]        quot_term;
    logic [DELTA_W-1:0]        mean_wide;
    logic [M2_W:0]             m2_wide;
    logic [M2_W-1:0]           m2_upd;
    logic                      found_calc;

    logic signed [MEAN_W:0]    avg_round;
    logic signed [MEAN_W:0]    avg_shift;
    logic [VAL_W-1:0]          avg_out;
    logic [DIV_W-FRAC_BITS-1:0] var_wide;
    logic [SPREAD_W-1:0]       spread_out;
    logic [OUT_W-1:0]          result;

    div_ctl_t                  div_ctl;
    logic [DIV_W-1:0]          div_dividend;
    logic [DIVSR_W-1:0]        div_divisor;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quot;
    logic                      mul_start;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_prod;
    logic                      out_free;
    logic                      emit;

    wrs_serial_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    wrs_serial_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (delta_mag),
        .mplier  (delta2_mag),
        .done    (mul_done),
        .product (mul_prod)
    );

    // datapath helpers
    always_comb
    begin
        in_time    = s_axis_tdata[TIME_W-1:0];
        in_value   = s_axis_tdata[TIME_W+VAL_W-1:TIME_W];
        keep_in    = (in_time >= win_begin_reg) && (in_time < win_end_reg);
        in_take    = s_axis_tvalid && s_axis_tready;

        x_val      = {value_reg, {MEAN_GUARD{1'b0}}};
        delta_calc = {x_val[MEAN_W-1], x_val} - {mean_reg[MEAN_W-1], mean_reg};
        delta_neg  = ~delta_reg + 1'b1;
        delta2_neg = ~delta2_reg + 1'b1;
        delta_mag  = delta_reg[DELTA_W-1] ? delta_neg[MAG_W-1:0] : delta_reg[MAG_W-1:0];
        delta2_mag = delta2_reg[DELTA_W-1] ? delta2_neg[MAG_W-1:0]
                                           : delta2_reg[MAG_W-1:0];

        cnt_upd    = (cnt_reg < COUNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
        sat_upd    = sat_reg || (cnt_reg >= COUNT_MAX);
        first_kept = (cnt_reg == '0);

        sum_wide   = {sum_reg[SUM_W-1], sum_reg}
                   + {{(SUM_W+1-VAL_W){value_reg[VAL_W-1]}}, value_reg};
        priority if (sum_wide > SUM_HI)
            sum_upd = SUM_HI[SUM_W-1:0];
        else if (sum_wide < SUM_LO)
            sum_upd = SUM_LO[SUM_W-1:0];
        else
            sum_upd = sum_wide[SUM_W-1:0];

        // signed step folded into one add: mean + (neg ? ~q + 1 : q)
        quot_term  = {1'b0, div_quot[MAG_W-1:0]};
        mean_wide  = {mean_reg[MEAN_W-1], mean_reg}
                   + (delta_reg[DELTA_W-1] ? ~quot_term : quot_term)
                   + {{(DELTA_W-1){1'b0}}, delta_reg[DELTA_W-1]};

        m2_wide    = {1'b0, m2_reg} + {1'b0, mul_prod[PROD_W-1:PROD_W-M2_W]};
        m2_upd     = m2_wide[M2_W] ? {M2_W{1'b1}} : m2_wide[M2_W-1:0];

        found_calc = (cnt_reg != '0) && (win_begin_reg < win_end_reg);

        avg_round  = {mean_reg[MEAN_W-1], mean_reg} + ROUND_HALF;
        avg_shift  = avg_round >>> MEAN_GUARD;
        priority if (avg_shift > AVG_HI)
            avg_out = AVG_HI[VAL_W-1:0];
        else if (avg_shift < AVG_LO)
            avg_out = AVG_LO[VAL_W-1:0];
        else
            avg_out = avg_shift[VAL_W-1:0];

        var_wide   = div_quot[DIV_W-1:FRAC_BITS];
        if (!var_en_reg)
            spread_out = '0;
        else if (|var_wide[DIV_W-FRAC_BITS-1:SPREAD_W])
            spread_out = {SPREAD_W{1'b1}};
        else
            spread_out = var_wide[SPREAD_W-1:0];

        if (found_reg)
            result = {{(OUT_W-OUT_USED){1'b0}}, sat_reg, spread_out, avg_out, sum_reg,
                      high_reg, low_reg, cnt_reg, 1'b1};
        else
            result = '0;

        out_free = !out_valid_reg || m_axis_tready;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        div_ctl.start = 1'b0;
        div_ctl.steps = DIV_STEP_W'(MAG_W);
        div_dividend  = {delta_mag, {(DIV_W-MAG_W){1'b0}}};
        div_divisor   = cnt_reg;
        mul_start     = 1'b0;
        emit          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (keep_in)
                        state_next = ST_TAKE;
                    else if (s_axis_tlast)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_TAKE:
                state_next = ST_MEAN_GO;
            ST_MEAN_GO:
            begin
                div_ctl.start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                    state_next = ST_MEAN_UPD;
            end
            ST_MEAN_UPD:
                state_next = ST_DELTA2;
            ST_DELTA2:
                state_next = ST_MUL_GO;
            ST_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (mul_done)
                    state_next = ST_M2_UPD;
            end
            ST_M2_UPD:
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            ST_FINISH:
            begin
                // variance needs n-1 > 0 in a valid window, otherwise straight to the result
                div_ctl.steps = DIV_STEP_W'(DIV_W);
                div_dividend  = m2_reg;
                div_divisor   = cnt_reg - 1'b1;
                if (found_calc && (cnt_reg > CNT_W'(1)))
                begin
                    div_ctl.start = 1'b1;
                    state_next    = ST_VAR_WAIT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_VAR_WAIT:
            begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_begin_reg <= '0;
            win_end_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW_BEGIN: win_begin_reg <= cfg_data;
                REG_WINDOW_END:   win_end_reg   <= cfg_data;
            endcase
        end
    end

    // accumulators, cleared once the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sat_reg  <= 1'b0;
            low_reg  <= '0;
            high_reg <= '0;
            sum_reg  <= '0;
            mean_reg <= '0;
            m2_reg   <= '0;
        end
        else if (emit)
        begin
            cnt_reg  <= '0;
            sat_reg  <= 1'b0;
            low_reg  <= '0;
            high_reg <= '0;
            sum_reg  <= '0;
            mean_reg <= '0;
            m2_reg   <= '0;
        end
        else if (state_reg == ST_TAKE)
        begin
            cnt_reg <= cnt_upd;
            sat_reg <= sat_upd;
            sum_reg <= sum_upd;
            if (first_kept || value_reg < low_reg)
                low_reg <= value_reg;
            if (first_kept || value_reg > high_reg)
                high_reg <= value_reg;
        end
        else if (state_reg == ST_MEAN_UPD)
        begin
            mean_reg <= mean_wide[MEAN_W-1:0];
        end
        else if (state_reg == ST_M2_UPD)
        begin
            m2_reg <= m2_upd;
        end
    end

    // per-request working registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            value_reg <= in_value;
            last_reg  <= s_axis_tlast;
        end
        if (state_reg == ST_TAKE)
            delta_reg <= delta_calc;
        if (state_reg == ST_DELTA2)
            delta2_reg <= delta_calc;
        if (state_reg == ST_FINISH)
        begin
            found_reg  <= found_calc;
            var_en_reg <= found_calc && (cnt_reg > CNT_W'(1));
        end
        if (emit)
            out_data_reg <= result;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
